// File: design/lswf_pkg.sv
// ----------------------------------------------------------------------------
// lswf_pkg: shared types and constants of the lidar wall-follow mode core
// Holds the sector codes, the mode and side codes, the register indexes and
// the field widths of the stream payloads.
// ----------------------------------------------------------------------------
`default_nettype none

package lswf_pkg;

  // Range samples are 16-bit millimeters; all ones means no return.
  localparam int unsigned RangeW = 16;
  localparam logic [RangeW-1:0] NoReturn = '1;

  // Band around the target distance for the side correction, in mm.
  localparam logic [RangeW:0] SideBand = 17'd50;

  // Register widths and indexes of the configuration port.
  localparam int unsigned ScanLenW = 13;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgAddrW = 1;
  localparam logic [CfgAddrW-1:0] RegScanLength = 1'd0;
  localparam logic [CfgAddrW-1:0] RegTargetDist = 1'd1;
  localparam logic [ScanLenW-1:0] ScanLengthRst = 13'd360;
  localparam logic [RangeW-1:0] TargetDistRst = 16'd500;

  // Sector codes; SecNone marks a sample outside every sector.
  typedef logic [2:0] sec_t;
  localparam sec_t SecFront = 3'd0;
  localparam sec_t SecFLeft = 3'd1;
  localparam sec_t SecLeft = 3'd2;
  localparam sec_t SecRight = 3'd3;
  localparam sec_t SecFRight = 3'd4;
  localparam sec_t SecNone = 3'd5;
  localparam int unsigned SecCount = 5;

  // Drive modes.
  typedef logic [1:0] mode_t;
  localparam mode_t ModeFind = 2'd0;
  localparam mode_t ModeTurn = 2'd1;
  localparam mode_t ModeFollow = 2'd2;

  // Follow corrections.
  typedef logic [1:0] side_t;
  localparam side_t SideNone = 2'd0;
  localparam side_t SideLeft = 2'd1;
  localparam side_t SideRight = 2'd2;

  // Stream payload widths (result padded to whole bytes).
  localparam int unsigned InDataW = 16;
  localparam int unsigned OutFieldsW = 2 + 2 + 6 * RangeW;
  localparam int unsigned OutDataW = ((OutFieldsW + 7) / 8) * 8;

endpackage

`default_nettype wire

// File: design/lidar_sector_wall_follow_mode_core.sv
// ----------------------------------------------------------------------------
// lidar_sector_wall_follow_mode_core: lidar sector minima and mode selection
// Keeps running minima of five angular sectors over one scan and, on the
// last sample of the scan, picks the wall-follow drive mode and side.
// ----------------------------------------------------------------------------
// Throughput: one sample per cycle, sustained, as long as results are taken.
// Result: the last sample of a scan is registered with its sector at the
// transfer; the minimum update and decision then load the result register
// when that sample leaves stage 1 and the result slot is free.
// Reset: sample index zero, all minima at no return, mode find, side none,
// scan_length 360 and target_distance 500; no clearing pass is needed.
`default_nettype none

module lidar_sector_wall_follow_mode_core #(
  parameter int unsigned MAX_SCAN_SAMPLES = 4096
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Configuration write port.
  input  wire logic                              cfg_we_i,
  input  wire logic [lswf_pkg::CfgAddrW-1:0]     cfg_addr_i,
  input  wire logic [lswf_pkg::CfgDataW-1:0]     cfg_wdata_i,
  // Sample stream.
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // tdata: [15:0] range_mm
  input  wire logic [lswf_pkg::InDataW-1:0]      s_axis_tdata_i,
  // Result stream.
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // tdata: [1:0] mode, [3:2] side, [19:4] nearest_mm, [35:20] front_mm,
  //        [51:36] front_left_mm, [67:52] left_mm, [83:68] right_mm,
  //        [99:84] front_right_mm, [103:100] zero
  output logic [lswf_pkg::OutDataW-1:0]          m_axis_tdata_o
);

  localparam int unsigned IdxW = $clog2(MAX_SCAN_SAMPLES);
  localparam int unsigned LenW = $clog2(MAX_SCAN_SAMPLES + 1);
  localparam int unsigned RW = lswf_pkg::RangeW;

  // Sector boundaries derived from the effective scan length.
  typedef struct packed {
    logic [LenW-1:0] len_m1;
    logic [LenW-1:0] h;
    logic [LenW-1:0] fl_end;
    logic [LenW-1:0] l_end;
    logic [LenW-1:0] r_beg;
    logic [LenW-1:0] fr_beg;
    logic [LenW-1:0] fr_end;
    logic [LenW-1:0] front_beg;
  } bounds_t;

  // Saturate the length to [8, MAX] and derive n = len/8, h = n/2 and the
  // sector edges; only shifts and narrow adds.
  function automatic bounds_t calc_bounds(logic [lswf_pkg::ScanLenW-1:0] sl);
    logic [31:0]     sl32;
    logic [LenW-1:0] len;
    logic [LenW-1:0] n;
    bounds_t         b;
    sl32 = 32'(sl);
    if (sl32 < 32'd8) begin
      len = LenW'(8);
    end else if (sl32 > MAX_SCAN_SAMPLES) begin
      len = LenW'(MAX_SCAN_SAMPLES);
    end else begin
      len = LenW'(sl32);
    end
    n           = len >> 3;
    b.len_m1    = len - LenW'(1);
    b.h         = n >> 1;
    b.fl_end    = b.h + n;
    b.l_end     = b.fl_end + n;
    b.r_beg     = b.l_end + (n << 1) + n;
    b.fr_beg    = b.r_beg + n;
    b.fr_end    = b.fr_beg + n;
    b.front_beg = len - b.h;
    return b;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers; boundaries are computed from the write data.
  // --------------------------------------------------------------------------
  bounds_t          bnd_q;
  logic [RW-1:0]    target_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bnd_q    <= calc_bounds(lswf_pkg::ScanLengthRst);
      target_q <= lswf_pkg::TargetDistRst;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        lswf_pkg::RegScanLength: bnd_q <= calc_bounds(cfg_wdata_i[lswf_pkg::ScanLenW-1:0]);
        lswf_pkg::RegTargetDist: target_q <= cfg_wdata_i[RW-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: classify the sample by its index within the scan.
  // --------------------------------------------------------------------------
  logic               s_xfer;
  logic               s2_fire;
  logic [IdxW-1:0]    idx_q;
  logic [LenW-1:0]    idx_ext;
  logic               is_last;
  lswf_pkg::sec_t     sec_d;

  logic               s1_v_q;
  logic               s1_last_q;
  lswf_pkg::sec_t     s1_sec_q;
  logic [RW-1:0]      s1_range_q;

  assign s_axis_tready_o = !s1_v_q || s2_fire;
  assign s_xfer          = s_axis_tvalid_i && s_axis_tready_o;
  assign idx_ext         = LenW'(idx_q);
  assign is_last         = idx_ext >= bnd_q.len_m1;

  // Sector lookup in priority order: front wraps around index zero.
  always_comb begin
    if (idx_ext < bnd_q.h || idx_ext >= bnd_q.front_beg) begin
      sec_d = lswf_pkg::SecFront;
    end else if (idx_ext < bnd_q.fl_end) begin
      sec_d = lswf_pkg::SecFLeft;
    end else if (idx_ext < bnd_q.l_end) begin
      sec_d = lswf_pkg::SecLeft;
    end else if (idx_ext >= bnd_q.r_beg && idx_ext < bnd_q.fr_beg) begin
      sec_d = lswf_pkg::SecRight;
    end else if (idx_ext >= bnd_q.fr_beg && idx_ext < bnd_q.fr_end) begin
      sec_d = lswf_pkg::SecFRight;
    end else begin
      sec_d = lswf_pkg::SecNone;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      s1_v_q    <= 1'b0;
      s1_last_q <= 1'b0;
      s1_sec_q  <= lswf_pkg::SecNone;
    end else begin
      if (s_xfer) begin
        idx_q     <= is_last ? '0 : idx_q + IdxW'(1);
        s1_v_q    <= 1'b1;
        s1_last_q <= is_last;
        s1_sec_q  <= sec_d;
      end else if (s2_fire) begin
        s1_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      s1_range_q <= s_axis_tdata_i[RW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: update one sector minimum; on the last sample decide the mode.
  // --------------------------------------------------------------------------
  logic [RW-1:0]      min_q [lswf_pkg::SecCount];
  logic [RW-1:0]      upd [lswf_pkg::SecCount];
  logic [RW-1:0]      near_a;
  logic [RW-1:0]      near_b;
  logic [RW-1:0]      nearest;
  lswf_pkg::mode_t    mode_q;
  lswf_pkg::mode_t    mode_d;
  lswf_pkg::side_t    side_q;
  lswf_pkg::side_t    side_d;
  logic               out_v_q;
  logic [lswf_pkg::OutDataW-1:0] out_data_q;

  // A non-final sample never waits; the final one needs a free result slot.
  assign s2_fire = s1_v_q && (!s1_last_q || !out_v_q || m_axis_tready_i);

  // Running minimum: only the sample's own sector can change.
  always_comb begin
    for (int k = 0; k < lswf_pkg::SecCount; k++) begin
      if (s1_sec_q == lswf_pkg::sec_t'(k) && s1_range_q < min_q[k]) begin
        upd[k] = s1_range_q;
      end else begin
        upd[k] = min_q[k];
      end
    end
  end

  // Smallest of the five sector minima.
  assign near_a  = (upd[0] < upd[1]) ? upd[0] : upd[1];
  assign near_b  = (upd[2] < upd[3]) ? upd[2] : upd[3];
  assign nearest = (near_a < near_b) ?
                   ((near_a < upd[4]) ? near_a : upd[4]) :
                   ((near_b < upd[4]) ? near_b : upd[4]);

  // Mode decision; any compared minimum equal to the target holds the state.
  always_comb begin
    mode_d = mode_q;
    side_d = side_q;
    if (upd[lswf_pkg::SecFront] == target_q || upd[lswf_pkg::SecFLeft] == target_q ||
        upd[lswf_pkg::SecFRight] == target_q) begin
      mode_d = mode_q;
    end else if (upd[lswf_pkg::SecFront] < target_q) begin
      mode_d = lswf_pkg::ModeTurn;
    end else if (upd[lswf_pkg::SecFLeft] > target_q && upd[lswf_pkg::SecFRight] < target_q) begin
      mode_d = lswf_pkg::ModeFollow;
      // Compare with one extra bit so that target minus or plus the band
      // cannot wrap.
      if (({1'b0, nearest} + lswf_pkg::SideBand) < {1'b0, target_q}) begin
        side_d = lswf_pkg::SideRight;
      end else if ({1'b0, nearest} > ({1'b0, target_q} + lswf_pkg::SideBand)) begin
        side_d = lswf_pkg::SideLeft;
      end else begin
        side_d = lswf_pkg::SideNone;
      end
    end else begin
      mode_d = lswf_pkg::ModeFind;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < lswf_pkg::SecCount; k++) begin
        min_q[k] <= lswf_pkg::NoReturn;
      end
      mode_q  <= lswf_pkg::ModeFind;
      side_q  <= lswf_pkg::SideNone;
      out_v_q <= 1'b0;
    end else begin
      if (s2_fire) begin
        for (int k = 0; k < lswf_pkg::SecCount; k++) begin
          min_q[k] <= s1_last_q ? lswf_pkg::NoReturn : upd[k];
        end
        if (s1_last_q) begin
          mode_q <= mode_d;
          side_q <= side_d;
        end
      end
      if (s2_fire && s1_last_q) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (s2_fire && s1_last_q) begin
      out_data_q <= lswf_pkg::OutDataW'({upd[lswf_pkg::SecFRight], upd[lswf_pkg::SecRight],
                                         upd[lswf_pkg::SecLeft], upd[lswf_pkg::SecFLeft],
                                         upd[lswf_pkg::SecFront], nearest, side_d, mode_d});
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_data_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // An empty classification stage always takes a new sample.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_v_q |-> s_axis_tready_o)
    else $error("sample input stalled with an empty pipeline");

  // The minima are refilled after each finished scan.
  a_refill_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_fire && s1_last_q) |=> (min_q[0] == lswf_pkg::NoReturn &&
      min_q[1] == lswf_pkg::NoReturn && min_q[2] == lswf_pkg::NoReturn &&
      min_q[3] == lswf_pkg::NoReturn && min_q[4] == lswf_pkg::NoReturn))
    else $error("sector minima not refilled after the last sample");

  // A new result only comes from the last sample of a scan.
  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(s2_fire && s1_last_q))
    else $error("result raised without a finished scan");

endmodule

`default_nettype wire

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the lidar sector wall-follow mode core
// Streams range samples into the core and checks every scan report against
// a local model of the sector minima and the mode decision. A short table
// of directed scans comes first, then random scans over many scan lengths
// and target distances, with random idle cycles on both stream sides.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // One scan report as eight 16-bit fields: mode, side, nearest, then the
  // five sector minima in output order.
  typedef logic [7:0][lswf_pkg::RangeW-1:0] scan_rep_t;

  typedef enum logic {RowCfg, RowSample} row_kind_t;
  typedef enum int {RelBelow, RelEqual, RelAbove} rel_t;

  typedef struct packed {
    row_kind_t                     kind;
    logic [lswf_pkg::CfgAddrW-1:0] addr;
    logic [lswf_pkg::RangeW-1:0]   val;
    logic [12:0]                   reps;
    logic                          typed;
    scan_rep_t                     want;
  } dir_row_t;

  localparam int unsigned SettleCycles = 4;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned IdleLimit    = 2000;
  localparam int unsigned StallPhase   = 2;
  localparam int unsigned BigPhase     = 5;

  logic                            clk_i;
  logic                            rst_ni          = 1'b0;
  logic                            cfg_we_i        = 1'b0;
  logic [lswf_pkg::CfgAddrW-1:0]   cfg_addr_i      = '0;
  logic [lswf_pkg::CfgDataW-1:0]   cfg_wdata_i     = '0;
  logic                            s_axis_tvalid_i = 1'b0;
  logic                            s_axis_tready_o;
  logic [lswf_pkg::InDataW-1:0]    s_axis_tdata_i  = '0;
  logic                            m_axis_tvalid_o;
  logic                            m_axis_tready_i = 1'b0;
  logic [lswf_pkg::OutDataW-1:0]   m_axis_tdata_o;

  lidar_sector_wall_follow_mode_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Model state: registers, scan position, sector minima, mode and side.
  logic [lswf_pkg::ScanLenW-1:0] cfg_scan_len;
  logic [lswf_pkg::RangeW-1:0]   cfg_target;
  int unsigned                   scan_pos;
  logic [lswf_pkg::RangeW-1:0]   sec_min [lswf_pkg::SecCount];
  lswf_pkg::mode_t               cur_mode;
  lswf_pkg::side_t               cur_side;

  scan_rep_t   pending_reports [$];
  int unsigned n_errors = 0;
  bit          no_idle  = 1'b0;
  bit          stall_req = 1'b0;

  // Scenario of the scan being generated: the minimum aimed at per sector.
  logic [lswf_pkg::RangeW-1:0] aim_min [lswf_pkg::SecCount];
  bit                          aim_hit [lswf_pkg::SecCount];
  bit                          noisy;

  string fld_name [8] = '{"mode", "side", "nearest_mm", "front_mm", "front_left_mm",
                          "left_mm", "right_mm", "front_right_mm"};

  function automatic scan_rep_t mk_rep(lswf_pkg::mode_t m, lswf_pkg::side_t sd,
                                       logic [lswf_pkg::RangeW-1:0] nr,
                                       logic [lswf_pkg::RangeW-1:0] f,
                                       logic [lswf_pkg::RangeW-1:0] fl,
                                       logic [lswf_pkg::RangeW-1:0] l,
                                       logic [lswf_pkg::RangeW-1:0] r,
                                       logic [lswf_pkg::RangeW-1:0] fr);
    scan_rep_t rep;
    rep[0] = lswf_pkg::RangeW'(m);
    rep[1] = lswf_pkg::RangeW'(sd);
    rep[2] = nr;
    rep[3] = f;
    rep[4] = fl;
    rep[5] = l;
    rep[6] = r;
    rep[7] = fr;
    return rep;
  endfunction

  function automatic scan_rep_t unpack_report(logic [lswf_pkg::OutDataW-1:0] d);
    scan_rep_t rep;
    rep[0] = lswf_pkg::RangeW'(d[1:0]);
    rep[1] = lswf_pkg::RangeW'(d[3:2]);
    for (int k = 2; k < 8; k++) rep[k] = d[4 + 16 * (k - 2) +: 16];
    return rep;
  endfunction

  // Appends one report to the queue of those still due.
  function automatic void queue_report(scan_rep_t rep);
    pending_reports.insert(pending_reports.size(), rep);
  endfunction

  function automatic void refill_minima();
    for (int k = 0; k < lswf_pkg::SecCount; k++) sec_min[k] = lswf_pkg::NoReturn;
  endfunction

  function automatic void model_reset();
    cfg_scan_len = lswf_pkg::ScanLengthRst;
    cfg_target   = lswf_pkg::TargetDistRst;
    scan_pos     = 0;
    refill_minima();
    cur_mode     = lswf_pkg::ModeFind;
    cur_side     = lswf_pkg::SideNone;
  endfunction

  // Scan length saturated to the range the core supports.
  function automatic int unsigned eff_len();
    int unsigned len;
    len = 32'(cfg_scan_len);
    if (len < 8) len = 8;
    if (len > 4096) len = 4096;
    return len;
  endfunction

  // Sector of sample i; the front sector wraps around index zero.
  function automatic lswf_pkg::sec_t sector_at(int unsigned i, int unsigned len);
    int unsigned n, h;
    n = len / 8;
    h = n / 2;
    if (i < h || i >= len - h) return lswf_pkg::SecFront;
    if (i < h + n) return lswf_pkg::SecFLeft;
    if (i < h + 2 * n) return lswf_pkg::SecLeft;
    if (i >= h + 5 * n && i < h + 6 * n) return lswf_pkg::SecRight;
    if (i >= h + 6 * n && i < h + 7 * n) return lswf_pkg::SecFRight;
    return lswf_pkg::SecNone;
  endfunction

  // Folds one sample into the minima; on the last sample of a scan it makes
  // the mode decision, builds the report and starts a fresh scan.
  function automatic bit step_sector_minima(input logic [lswf_pkg::RangeW-1:0] r,
                                            output scan_rep_t rep);
    int unsigned len;
    lswf_pkg::sec_t sc;
    logic [lswf_pkg::RangeW-1:0] nr, t, f, fl, fr;
    int d, ts;
    len = eff_len();
    sc = sector_at(scan_pos, len);
    rep = '0;
    if (sc != lswf_pkg::SecNone && r < sec_min[sc]) sec_min[sc] = r;
    if (scan_pos + 1 < len) begin
      scan_pos++;
      return 1'b0;
    end
    nr = lswf_pkg::NoReturn;
    for (int k = 0; k < lswf_pkg::SecCount; k++) if (sec_min[k] < nr) nr = sec_min[k];
    t  = cfg_target;
    f  = sec_min[lswf_pkg::SecFront];
    fl = sec_min[lswf_pkg::SecFLeft];
    fr = sec_min[lswf_pkg::SecFRight];
    d  = int'(nr);
    ts = int'(t);
    // Any compared minimum exactly at the target keeps mode and side.
    if (f != t && fl != t && fr != t) begin
      if (f < t) begin
        cur_mode = lswf_pkg::ModeTurn;
      end else if (fl > t && fr < t) begin
        if (d < ts - int'(lswf_pkg::SideBand)) cur_side = lswf_pkg::SideRight;
        else if (d > ts + int'(lswf_pkg::SideBand)) cur_side = lswf_pkg::SideLeft;
        else cur_side = lswf_pkg::SideNone;
        cur_mode = lswf_pkg::ModeFollow;
      end else begin
        cur_mode = lswf_pkg::ModeFind;
      end
    end
    rep = mk_rep(cur_mode, cur_side, nr, f, fl, sec_min[lswf_pkg::SecLeft],
                 sec_min[lswf_pkg::SecRight], fr);
    scan_pos = 0;
    refill_minima();
    return 1'b1;
  endfunction

  function automatic logic [lswf_pkg::RangeW-1:0] pick_rel(logic [lswf_pkg::RangeW-1:0] t,
                                                           rel_t rel);
    case (rel)
      RelBelow: return (t == 0) ? t : lswf_pkg::RangeW'($urandom_range(0, t - 1));
      RelAbove: return lswf_pkg::RangeW'($urandom_range(t + 1, 65535));
      default:  return t;
    endcase
  endfunction

  // Ten-way draw: one in ten exactly at the target, n_below in ten below.
  function automatic rel_t draw_rel(int unsigned n_below);
    int unsigned v;
    v = $urandom_range(0, 9);
    if (v == 0) return RelEqual;
    if (v <= n_below) return RelBelow;
    return RelAbove;
  endfunction

  function automatic void new_scenario();
    logic [lswf_pkg::RangeW-1:0] t;
    rel_t rel;
    t = cfg_target;
    noisy = ($urandom_range(0, 5) == 0);
    aim_min[lswf_pkg::SecFront] = pick_rel(t, draw_rel(3));
    aim_min[lswf_pkg::SecFLeft] = pick_rel(t, draw_rel(2));
    rel = draw_rel(7);
    // Right-front minimum near the side band edges now and then.
    if (rel == RelBelow && t >= 51 && $urandom_range(0, 1) == 1)
      aim_min[lswf_pkg::SecFRight] = lswf_pkg::RangeW'(t - 51 + $urandom_range(0, 2));
    else
      aim_min[lswf_pkg::SecFRight] = pick_rel(t, rel);
    aim_min[lswf_pkg::SecLeft]  = $urandom_range(0, 1) ?
                                  lswf_pkg::RangeW'($urandom_range(0, 65535)) :
                                  pick_rel(t, RelAbove);
    aim_min[lswf_pkg::SecRight] = $urandom_range(0, 1) ?
                                  lswf_pkg::RangeW'($urandom_range(0, 65535)) :
                                  pick_rel(t, RelAbove);
    for (int k = 0; k < lswf_pkg::SecCount; k++) aim_hit[k] = 1'b0;
  endfunction

  // First sample of each sector lands on the aimed minimum, the rest at or above.
  function automatic logic [lswf_pkg::RangeW-1:0] next_sample();
    lswf_pkg::sec_t sc;
    int v;
    sc = sector_at(scan_pos, eff_len());
    if (noisy || sc == lswf_pkg::SecNone) return lswf_pkg::RangeW'($urandom_range(0, 65535));
    if (!aim_hit[sc]) begin
      aim_hit[sc] = 1'b1;
      return aim_min[sc];
    end
    if ($urandom_range(0, 7) == 0) return lswf_pkg::NoReturn;
    v = aim_min[sc] + $urandom_range(0, 3000);
    if (v > 65535) v = 65535;
    return lswf_pkg::RangeW'(v);
  endfunction

  function automatic logic [lswf_pkg::RangeW-1:0] pick_target();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 16'd65534;
      2: return lswf_pkg::RangeW'($urandom_range(0, 60));
      3: return lswf_pkg::RangeW'($urandom_range(65470, 65534));
      4: return lswf_pkg::RangeW'($urandom_range(0, 65534));
      default: return lswf_pkg::RangeW'($urandom_range(100, 3000));
    endcase
  endfunction

  // One sample transfer, after a random number of idle cycles.
  task automatic push_range(input logic [lswf_pkg::RangeW-1:0] r, output bit got,
                            output scan_rep_t rep);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= r;
    do @(posedge clk_i); while (!s_axis_tready_o);
    got = step_sector_minima(r, rep);
  endtask

  // Each register write drops its write enable before returning, so writes never overlap.
  task automatic write_reg(input logic [lswf_pkg::CfgAddrW-1:0] a,
                           input logic [lswf_pkg::CfgDataW-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= a;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (a == lswf_pkg::RegScanLength) cfg_scan_len = v[lswf_pkg::ScanLenW-1:0];
    else cfg_target = v;
    @(posedge clk_i);
  endtask

  // Stop sending, wait for all reports, then let the pipeline drain.
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Result receiver: random ready gaps, plus one long hold when requested.
  initial begin
    int unsigned gap;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (stall_req) begin
        m_axis_tready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        stall_req = 1'b0;
      end
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  // Each report transfer is compared field by field with the oldest one due.
  always @(posedge clk_i) begin
    scan_rep_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = unpack_report(m_axis_tdata_o);
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected report, expected none, got %h", $time, got);
        n_errors++;
      end else begin
        want = pending_reports.pop_front();
        for (int k = 0; k < 8; k++) begin
          if (got[k] !== want[k]) begin
            $display("%0t: %s expected %0d, got %0d", $time, fld_name[k], want[k], got[k]);
            n_errors++;
          end
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    int unsigned idle_cycles;
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    dir_row_t                      dir_tab [8];
    bit                            got;
    scan_rep_t                     rep;
    logic [lswf_pkg::CfgDataW-1:0] len_w;
    int unsigned                   count, phase, n_items;
    bit                            part;

    // Minimum scan with only no-return samples, then a 16-sample scan with
    // a zero range straight ahead.
    dir_tab[0] = '{RowCfg, lswf_pkg::RegScanLength, 16'hE000, 13'd1, 1'b0, '0};
    dir_tab[1] = '{RowCfg, lswf_pkg::RegTargetDist, 16'd500, 13'd1, 1'b0, '0};
    dir_tab[2] = '{RowSample, '0, lswf_pkg::NoReturn, 13'd7, 1'b0, '0};
    dir_tab[3] = '{RowSample, '0, lswf_pkg::NoReturn, 13'd1, 1'b1,
                   mk_rep(lswf_pkg::ModeFind, lswf_pkg::SideNone, lswf_pkg::NoReturn,
                          lswf_pkg::NoReturn, lswf_pkg::NoReturn, lswf_pkg::NoReturn,
                          lswf_pkg::NoReturn, lswf_pkg::NoReturn)};
    dir_tab[4] = '{RowCfg, lswf_pkg::RegScanLength, 16'd16, 13'd1, 1'b0, '0};
    dir_tab[5] = '{RowSample, '0, 16'd0, 13'd1, 1'b0, '0};
    dir_tab[6] = '{RowSample, '0, lswf_pkg::NoReturn, 13'd14, 1'b0, '0};
    dir_tab[7] = '{RowSample, '0, lswf_pkg::NoReturn, 13'd1, 1'b1,
                   mk_rep(lswf_pkg::ModeTurn, lswf_pkg::SideNone, 16'd0, 16'd0,
                          lswf_pkg::NoReturn, lswf_pkg::NoReturn, lswf_pkg::NoReturn,
                          lswf_pkg::NoReturn)};

    model_reset();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table.
    for (int i = 0; i < 8; i++) begin
      if (dir_tab[i].kind == RowCfg) begin
        settle();
        write_reg(dir_tab[i].addr, dir_tab[i].val);
      end else begin
        for (int k = 0; k < dir_tab[i].reps; k++) begin
          push_range(dir_tab[i].val, got, rep);
          if (dir_tab[i].typed && k == dir_tab[i].reps - 1)
            queue_report(dir_tab[i].want);
          else if (got)
            queue_report(rep);
        end
      end
    end

    // Random phases: new scan length and maybe target, then whole scans or
    // a broken-off scan that the next length change cuts short.
    phase   = 0;
    n_items = 0;
    while (n_items < 850) begin
      settle();
      no_idle = ($urandom_range(0, 4) == 0);
      part    = 1'b0;
      if (phase == StallPhase) begin
        // Long receiver hold with minimum scans backs the core up.
        write_reg(lswf_pkg::RegScanLength, 16'd8);
        no_idle   = 1'b1;
        stall_req = 1'b1;
        count     = 48;
      end else if (phase == BigPhase) begin
        // A long scan at the saturated length, ended by the next length
        // change.
        write_reg(lswf_pkg::RegScanLength, 16'hFFFF);
        write_reg(lswf_pkg::RegTargetDist, lswf_pkg::RangeW'($urandom_range(100, 3000)));
        count = 300;
      end else begin
        case ($urandom_range(0, 9))
          0: len_w = {3'($urandom_range(0, 7)), 10'd0, 3'($urandom_range(0, 7))};
          1: begin
            len_w = lswf_pkg::CfgDataW'($urandom_range(0, 65535));
            part  = 1'b1;
          end
          2: begin
            len_w = lswf_pkg::CfgDataW'($urandom_range(65, 4096));
            part  = 1'b1;
          end
          default: len_w = lswf_pkg::CfgDataW'($urandom_range(8, 48));
        endcase
        write_reg(lswf_pkg::RegScanLength, len_w);
        if ($urandom_range(0, 2) == 0) write_reg(lswf_pkg::RegTargetDist, pick_target());
        if (part)
          count = $urandom_range(1, 40);
        else if ($urandom_range(0, 5) == 0)
          count = $urandom_range(1, eff_len());
        else
          count = $urandom_range(1, 3) * eff_len();
      end
      for (int k = 0; k < count; k++) begin
        if (scan_pos == 0) new_scenario();
        push_range(next_sample(), got, rep);
        if (got) queue_report(rep);
      end
      n_items += count;
      phase++;
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
design/lswf_pkg.sv
design/lidar_sector_wall_follow_mode_core.sv
tb/tb.sv
